[hw/rtl/m68kea_pkg.sv]
package m68kea_pkg;

    // Request operation codes.
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_START = 2'd1,
        OP_EXT   = 2'd2,
        OP_MEM   = 2'd3
    } t_op;

    // Result kinds.
    typedef enum logic [2:0] {
        K_NEED    = 3'd0,
        K_READ    = 3'd1,
        K_DONE    = 3'd2,
        K_REGID   = 3'd3,
        K_BUSERR  = 3'd4,
        K_INVALID = 3'd5
    } t_kind;

    // Sequencer phases.
    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_ABS_W  = 4'd1,
        PH_ABS_HI = 4'd2,
        PH_ABS_LO = 4'd3,
        PH_DISP   = 4'd4,
        PH_INDEX  = 4'd5,
        PH_BD_W   = 4'd6,
        PH_BD_HI  = 4'd7,
        PH_BD_LO  = 4'd8,
        PH_MEM    = 4'd9,
        PH_OD_W   = 4'd10,
        PH_OD_HI  = 4'd11,
        PH_OD_LO  = 4'd12
    } t_phase;

    // Effective address modes.
    localparam logic [2:0] MODE_DN      = 3'd0;
    localparam logic [2:0] MODE_AN      = 3'd1;
    localparam logic [2:0] MODE_IND     = 3'd2;
    localparam logic [2:0] MODE_POSTINC = 3'd3;
    localparam logic [2:0] MODE_PREDEC  = 3'd4;
    localparam logic [2:0] MODE_DISP    = 3'd5;
    localparam logic [2:0] MODE_INDEX   = 3'd6;
    localparam logic [2:0] MODE_EXT     = 3'd7;

    // Mode 7 submodes.
    localparam logic [2:0] SUB_ABS_W    = 3'd0;
    localparam logic [2:0] SUB_ABS_L    = 3'd1;
    localparam logic [2:0] SUB_PC_DISP  = 3'd2;
    localparam logic [2:0] SUB_PC_INDEX = 3'd3;

    // Displacement size codes of the full extension format.
    localparam logic [1:0] DSZ_WORD = 2'd2;
    localparam logic [1:0] DSZ_LONG = 2'd3;

    // Index/indirect selection that computes the address without a memory read.
    localparam logic [2:0] IIS_NO_MEMORY = 3'd0;

    localparam logic [2:0] A7_REG    = 3'd7;
    localparam logic [2:0] SIZE_BYTE = 3'd1;
    localparam logic [2:0] SIZE_WORD = 3'd2;

    // One write into the register file.
    typedef struct packed {
        logic        en;
        logic [3:0]  addr;
        logic [31:0] data;
    } t_rf_wr;

    // One request as held in the compute stage.
    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  reg_select;
        logic [31:0] reg_value;
        logic [2:0]  mode;
        logic [2:0]  reg_n;
        logic [2:0]  access_size;
        logic [31:0] program_counter;
        logic [15:0] extension_word;
        logic [31:0] memory_data;
        logic        memory_fault;
    } t_req_item;

    function automatic logic [31:0] sext16(input logic [15:0] w);
        sext16 = {{16{w[15]}}, w};
    endfunction

    function automatic logic [31:0] sext8(input logic [7:0] b);
        sext8 = {{24{b[7]}}, b};
    endfunction

endpackage

[hw/rtl/m68kea_req_if.sv]
interface m68kea_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [3:0]  reg_select;
    logic [31:0] reg_value;
    logic [2:0]  mode;
    logic [2:0]  reg_n;
    logic [2:0]  access_size;
    logic [31:0] program_counter;
    logic [15:0] extension_word;
    logic [31:0] memory_data;
    logic        memory_fault;

    modport source (
        output valid, operation, reg_select, reg_value, mode, reg_n, access_size,
               program_counter, extension_word, memory_data, memory_fault,
        input  ready
    );
    modport sink (
        input  valid, operation, reg_select, reg_value, mode, reg_n, access_size,
               program_counter, extension_word, memory_data, memory_fault,
        output ready
    );
endinterface

[hw/rtl/m68kea_rsp_if.sv]
interface m68kea_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  result_kind;
    logic [31:0] address;

    modport source (output valid, result_kind, address, input ready);
    modport sink (input valid, result_kind, address, output ready);
endinterface

[hw/rtl/m68kea_cfg_if.sv]
interface m68kea_cfg_if;
    logic valid;
    logic ready;
    logic cpu_is_020_or_later;

    modport source (output valid, cpu_is_020_or_later, input ready);
    modport sink (input valid, cpu_is_020_or_later, output ready);
endinterface

[hw/rtl/m68kea_regfile.sv]
module m68kea_regfile
    import m68kea_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rd_en,
    input  logic [3:0]  i_rd_addr,
    input  t_rf_wr      i_wr,
    output logic [31:0] o_rd_data
);

    logic [31:0] r_mem [16];
    logic [15:0] r_valid;
    logic [31:0] r_rd_data;
    logic        r_rd_vld;
    logic        r_fwd;
    logic [31:0] r_fwd_data;

    // Memory array: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_fwd_data <= i_wr.data;
        end
    end

    // Written-entry flags and read-during-write bypass control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
            r_fwd    <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_valid[i_rd_addr];
                r_fwd    <= i_wr.en && (i_wr.addr == i_rd_addr);
            end
        end
    end

    // An entry never written reads as zero; a same-cycle write wins.
    assign o_rd_data = r_fwd ? r_fwd_data : (r_rd_vld ? r_rd_data : '0);

endmodule

[hw/rtl/m68k_effective_address_unit.sv]
// Effective address unit for 68000/68020 operands. The block takes one request per clock
// and gives its result, if any, as follows: acceptance reads the 16-entry register file
// (D0-D7, A0-A7), a synchronous memory with a registered read port, and the compute stage
// then computes in the sequencer and loads the result into the output register.
// A register write or an address register update from postincrement or predecrement is
// bypassed to a read of the same entry in the next request, so requests may follow each
// other without gaps. The rate is one request per cycle whenever the result side takes
// results; a stalled result holds the compute stage, and one further request waits there.
// Register direct modes answer with a register id, indirect modes answer at once, and the
// displacement, index and absolute modes ask for each extension word (high word first for
// a long) and, for memory indirect, for one long memory read.
module m68k_effective_address_unit
    import m68kea_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    m68kea_cfg_if.sink   i_cfg,
    m68kea_req_if.sink   i_req,
    m68kea_rsp_if.source o_rsp
);

    logic        r_cfg_020;
    logic        r_s1_valid;
    t_req_item   r_s1;
    t_phase      r_phase, n_phase;
    logic [31:0] r_work, n_work;
    logic [31:0] r_index, n_index;
    logic [15:0] r_held, n_held;
    logic [15:0] r_high, n_high;
    logic        r_out_valid;
    t_kind       r_out_kind;
    logic [31:0] r_out_addr;

    logic        req_accept;
    logic        out_free;
    logic        s1_fire;
    t_op         s1_op;
    logic [3:0]  rd_addr;
    logic [31:0] opnd;
    t_rf_wr      rf_wr_raw;
    t_rf_wr      rf_wr;
    logic        res_vld;
    t_kind       res_kind;
    logic [31:0] res_addr;

    logic [15:0] w;
    logic [2:0]  size_eff;
    logic [31:0] an_post;
    logic [31:0] an_pre;
    logic [31:0] idx_s;
    logic [31:0] idx_sh;
    logic        full_fmt;
    logic [31:0] brief_sum;
    logic [31:0] bd_disp;
    logic [31:0] bd_sum;
    logic [31:0] ab_wa;
    logic [31:0] ab_idx;
    logic [2:0]  ab_iis;
    logic [31:0] ab_sum;
    logic [31:0] ao_wa;
    logic [31:0] ao_sum;

    // Handshakes.
    assign i_cfg.ready = 1'b1;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign s1_fire     = r_s1_valid && out_free;
    assign i_req.ready = !r_s1_valid || s1_fire;
    assign req_accept  = i_req.valid && i_req.ready;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_020 <= 1'b0;
        end else if (i_cfg.valid) begin
            r_cfg_020 <= i_cfg.cpu_is_020_or_later;
        end
    end

    // Register file read address: An for a start, the index register for a word.
    assign rd_addr = (t_op'(i_req.operation) == OP_START) ? {1'b1, i_req.reg_n}
                                                          : i_req.extension_word[15:12];
    assign rf_wr   = '{en: rf_wr_raw.en && s1_fire, addr: rf_wr_raw.addr,
                       data: rf_wr_raw.data};

    m68kea_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (req_accept),
        .i_rd_addr (rd_addr),
        .i_wr      (rf_wr),
        .o_rd_data (opnd)
    );

    // Compute stage holding register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_s1_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_s1 <= '{operation: i_req.operation, reg_select: i_req.reg_select,
                      reg_value: i_req.reg_value, mode: i_req.mode, reg_n: i_req.reg_n,
                      access_size: i_req.access_size,
                      program_counter: i_req.program_counter,
                      extension_word: i_req.extension_word,
                      memory_data: i_req.memory_data,
                      memory_fault: i_req.memory_fault};
        end
    end

    assign s1_op = t_op'(r_s1.operation);
    assign w     = r_s1.extension_word;

    // Postincrement and predecrement; a byte on A7 moves by two.
    assign size_eff = ((r_s1.mode == MODE_POSTINC || r_s1.mode == MODE_PREDEC) &&
                       r_s1.access_size == SIZE_BYTE && r_s1.reg_n == A7_REG)
                      ? SIZE_WORD : r_s1.access_size;
    assign an_post  = opnd + {29'd0, size_eff};
    assign an_pre   = opnd - {29'd0, size_eff};

    // Index register: sign extended word or long, scaled on 68020 and later.
    assign idx_s     = w[11] ? opnd : sext16(opnd[15:0]);
    assign idx_sh    = r_cfg_020 ? (idx_s << w[10:9]) : idx_s;
    assign full_fmt  = r_cfg_020 && w[8];
    assign brief_sum = r_work + idx_sh + sext8(w[7:0]);

    // Shared displacement adder for word or long displacements.
    assign bd_disp = (r_phase == PH_BD_LO || r_phase == PH_OD_LO) ? {r_high, w} : sext16(w);
    assign bd_sum  = r_work + bd_disp;

    // Base displacement applied: pre-indexing, then either done or a memory read.
    assign ab_wa  = (r_phase == PH_INDEX) ? (w[7] ? '0 : r_work) : bd_sum;
    assign ab_idx = (r_phase == PH_INDEX) ? (w[6] ? '0 : idx_sh) : r_index;
    assign ab_iis = (r_phase == PH_INDEX) ? w[2:0] : r_held[2:0];
    assign ab_sum = ab_iis[2] ? ab_wa : ab_wa + ab_idx;

    // Outer displacement applied: post-indexing.
    assign ao_wa  = (s1_op == OP_MEM) ? r_s1.memory_data : bd_sum;
    assign ao_sum = r_held[2] ? ao_wa + r_index : ao_wa;

    // Sequencer next state.
    always_comb begin
        n_phase = r_phase;
        n_work  = r_work;
        n_index = r_index;
        n_held  = r_held;
        n_high  = r_high;
        case (s1_op)
            OP_START: begin
                n_phase = PH_IDLE;
                case (r_s1.mode)
                    MODE_DISP: begin
                        n_work  = opnd;
                        n_phase = PH_DISP;
                    end
                    MODE_INDEX: begin
                        n_work  = opnd;
                        n_phase = PH_INDEX;
                    end
                    MODE_EXT: begin
                        case (r_s1.reg_n)
                            SUB_ABS_W: n_phase = PH_ABS_W;
                            SUB_ABS_L: n_phase = PH_ABS_HI;
                            SUB_PC_DISP: begin
                                n_work  = r_s1.program_counter;
                                n_phase = PH_DISP;
                            end
                            SUB_PC_INDEX: begin
                                n_work  = r_s1.program_counter;
                                n_phase = PH_INDEX;
                            end
                            default: n_phase = PH_IDLE;
                        endcase
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end
            OP_EXT: begin
                case (r_phase)
                    PH_ABS_W, PH_ABS_LO, PH_DISP: n_phase = PH_IDLE;
                    PH_ABS_HI: begin
                        n_high  = w;
                        n_phase = PH_ABS_LO;
                    end
                    PH_BD_HI: begin
                        n_high  = w;
                        n_phase = PH_BD_LO;
                    end
                    PH_OD_HI: begin
                        n_high  = w;
                        n_phase = PH_OD_LO;
                    end
                    PH_INDEX: begin
                        if (!full_fmt) begin
                            n_phase = PH_IDLE;
                        end else begin
                            n_held  = w;
                            n_index = w[6] ? '0 : idx_sh;
                            n_work  = ab_wa;
                            case (w[5:4])
                                DSZ_WORD: n_phase = PH_BD_W;
                                DSZ_LONG: n_phase = PH_BD_HI;
                                default: begin
                                    n_work  = ab_sum;
                                    n_phase = (ab_iis == IIS_NO_MEMORY) ? PH_IDLE : PH_MEM;
                                end
                            endcase
                        end
                    end
                    PH_BD_W, PH_BD_LO: begin
                        n_work  = ab_sum;
                        n_phase = (ab_iis == IIS_NO_MEMORY) ? PH_IDLE : PH_MEM;
                    end
                    PH_OD_W, PH_OD_LO: begin
                        n_work  = bd_sum;
                        n_phase = PH_IDLE;
                    end
                    default: n_phase = r_phase;
                endcase
            end
            OP_MEM: begin
                if (r_phase == PH_MEM) begin
                    if (r_s1.memory_fault) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_work = r_s1.memory_data;
                        case (r_held[1:0])
                            DSZ_WORD: n_phase = PH_OD_W;
                            DSZ_LONG: n_phase = PH_OD_HI;
                            default:  n_phase = PH_IDLE;
                        endcase
                    end
                end
            end
            default: n_phase = r_phase;
        endcase
    end

    // Sequencer outputs: the result and the register file write.
    always_comb begin
        res_vld   = 1'b0;
        res_kind  = K_NEED;
        res_addr  = '0;
        rf_wr_raw = '{en: 1'b0, addr: r_s1.reg_select, data: r_s1.reg_value};
        case (s1_op)
            OP_WRITE: rf_wr_raw.en = 1'b1;
            OP_START: begin
                res_vld = 1'b1;
                case (r_s1.mode)
                    MODE_DN, MODE_AN: begin
                        res_kind = K_REGID;
                        res_addr = {26'd0, r_s1.mode, r_s1.reg_n};
                    end
                    MODE_IND: begin
                        res_kind = K_DONE;
                        res_addr = opnd;
                    end
                    MODE_POSTINC: begin
                        res_kind  = K_DONE;
                        res_addr  = opnd;
                        rf_wr_raw = '{en: 1'b1, addr: {1'b1, r_s1.reg_n}, data: an_post};
                    end
                    MODE_PREDEC: begin
                        res_kind  = K_DONE;
                        res_addr  = an_pre;
                        rf_wr_raw = '{en: 1'b1, addr: {1'b1, r_s1.reg_n}, data: an_pre};
                    end
                    MODE_EXT: begin
                        if (r_s1.reg_n[2]) begin
                            res_kind = K_INVALID;
                        end
                    end
                    default: res_kind = K_NEED;
                endcase
            end
            OP_EXT: begin
                res_vld = 1'b1;
                case (r_phase)
                    PH_ABS_W: begin
                        res_kind = K_DONE;
                        res_addr = sext16(w);
                    end
                    PH_ABS_LO: begin
                        res_kind = K_DONE;
                        res_addr = {r_high, w};
                    end
                    PH_DISP: begin
                        res_kind = K_DONE;
                        res_addr = bd_sum;
                    end
                    PH_ABS_HI, PH_BD_HI, PH_OD_HI: res_kind = K_NEED;
                    PH_INDEX: begin
                        if (!full_fmt) begin
                            res_kind = K_DONE;
                            res_addr = brief_sum;
                        end else if (w[5:4] != DSZ_WORD && w[5:4] != DSZ_LONG) begin
                            res_kind = (ab_iis == IIS_NO_MEMORY) ? K_DONE : K_READ;
                            res_addr = ab_sum;
                        end
                    end
                    PH_BD_W, PH_BD_LO: begin
                        res_kind = (ab_iis == IIS_NO_MEMORY) ? K_DONE : K_READ;
                        res_addr = ab_sum;
                    end
                    PH_OD_W, PH_OD_LO: begin
                        res_kind = K_DONE;
                        res_addr = ao_sum;
                    end
                    default: res_vld = 1'b0;
                endcase
            end
            OP_MEM: begin
                if (r_phase == PH_MEM) begin
                    res_vld = 1'b1;
                    if (r_s1.memory_fault) begin
                        res_kind = K_BUSERR;
                        res_addr = r_work;
                    end else if (r_held[1:0] != DSZ_WORD && r_held[1:0] != DSZ_LONG) begin
                        res_kind = K_DONE;
                        res_addr = ao_sum;
                    end
                end
            end
            default: res_vld = 1'b0;
        endcase
    end

    // Sequencer state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_work  <= '0;
            r_index <= '0;
            r_held  <= '0;
            r_high  <= '0;
        end else if (s1_fire) begin
            r_phase <= n_phase;
            r_work  <= n_work;
            r_index <= n_index;
            r_held  <= n_held;
            r_high  <= n_high;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= res_vld;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && res_vld) begin
            r_out_kind <= res_kind;
            r_out_addr <= res_addr;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.result_kind = r_out_kind;
    assign o_rsp.address     = r_out_addr;

`ifndef SYNTH
    // A memory read phase is only entered with an indirect I/IS code.
    a_mem_needs_iis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_MEM) |-> (r_held[2:0] != IIS_NO_MEMORY))
        else $error("memory phase without indirect code");

    // A produced result is presented in the following cycle.
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && res_vld) |=> r_out_valid)
        else $error("result lost");

    // Register direct modes answer with a register id.
    a_regid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && s1_op == OP_START &&
         (r_s1.mode == MODE_DN || r_s1.mode == MODE_AN))
        |=> (r_out_valid && r_out_kind == K_REGID))
        else $error("register direct did not give a register id");
`endif

endmodule
